// File: rtl/core/falling_sand_grid_step_core_assert.svh
`ifndef FALLING_SAND_GRID_STEP_CORE_ASSERT_SVH
`define FALLING_SAND_GRID_STEP_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FSG_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FSG_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/fsg_pkg.sv
package fsg_pkg;

  localparam int LFSR_W      = 16;
  localparam logic [LFSR_W-1:0] SEED_RST  = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  localparam int SPAWN_COL_W = 4;
  localparam int ROW_IDX_W   = 4;
  localparam int ROW_BITS_W  = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  // register index is paddr[2]
  localparam logic REG_SEED = 1'b0;

  typedef struct packed {
    logic load_below;
    logic below_from_cur;
    logic load_cur;
    logic step;
    logic first_col;
    logic last_col;
  } cell_ctl_t;

endpackage

// File: rtl/core/falling_sand_grid_step_core.sv
// Falling-sand grid engine: one input item is one frame of the simulation.
// Input stream in_*: tdata bit 0 spawn_enable, bits 4:1 spawn_column. When
// spawn is set a grain is placed in the top row before that row is swept.
// Result stream out_*: one item per grid row, top row first, GRID_HEIGHT
// items per frame; tlast marks the bottom row.
// Config (cfg_*, APB-style): register 0 at address 0 is the 16-bit random
// seed; a write reloads the random generator. pready is tied high.
// The sweep is done by the single cell update unit, which visits one cell per
// cycle; then the rows are read back through the grid memory (one read port,
// one write port) and come out one row per cycle while the receiver is ready.
// in_tready is high only between frames; a result may still wait in the output
// register while a new item is taken. A stalled receiver freezes the read-back
// with nothing lost.
// Reset empties the grid (per-row valid bits, no clearing pass), reloads the
// seed with its reset value and leaves the block ready.
`include "falling_sand_grid_step_core_assert.svh"

module falling_sand_grid_step_core
  import fsg_pkg::*;
#(
  parameter int GRID_HEIGHT = 16,
  parameter int GRID_WIDTH  = 16
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] spawn_enable, [4:1] spawn_column
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [3:0] row_index, [19:4] row_bits
  output logic                   out_tlast,  // last_row
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int ROW_W = $clog2(GRID_HEIGHT);
  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int CNT_W = $clog2(GRID_HEIGHT + 1);
  localparam int BITS_XW = (GRID_WIDTH > ROW_BITS_W) ? GRID_WIDTH : ROW_BITS_W;
  localparam int IDX_XW  = (CNT_W > ROW_IDX_W) ? CNT_W : ROW_IDX_W;
  localparam logic [ROW_W-1:0] ROW_BOT  = ROW_W'(GRID_HEIGHT - 1);
  localparam logic [ROW_W-1:0] ROW_SWP0 = ROW_W'(GRID_HEIGHT - 2);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(GRID_HEIGHT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDB   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_WB0   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  // ---------------- configuration ----------------
  logic              cfg_wr;
  logic [LFSR_W-1:0] seed_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                  & (cfg_paddr[2] == REG_SEED);
  assign cfg_prdata = (cfg_paddr[2] == REG_SEED) ? CFG_DW'(seed_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
    end else if (cfg_wr) begin
      seed_r <= cfg_pwdata[LFSR_W-1:0];
    end
  end

  // ---------------- sequencer state ----------------
  logic [2:0]             state_r, state_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [CNT_W-1:0]       emit_rd_r, emit_rd_nxt;
  logic                   pend_r, pend_nxt;
  logic                   spawn_en_r;
  logic [SPAWN_COL_W-1:0] spawn_col_r;

  // ---------------- grid memory ----------------
  logic [GRID_WIDTH-1:0]  grid_mem [GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] row_vld_r;
  logic                   mem_we, mem_re;
  logic [ROW_W-1:0]       wr_addr, rd_addr;
  logic [GRID_WIDTH-1:0]  wr_data;
  logic [GRID_WIDTH-1:0]  rd_data_r;
  logic                   rd_vld_r;
  logic [GRID_WIDTH-1:0]  rd_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= grid_mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  // a row never written reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (mem_we) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

  // ---------------- cell unit and random bits ----------------
  cell_ctl_t             ctl;
  logic [GRID_WIDTH-1:0] ld_data, spawn_mask;
  logic [GRID_WIDTH-1:0] cur_q, below_q;
  logic                  rnd_bit, rnd_req;

  fsg_cell_unit #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_cell (
    .clk     (clk),
    .ctl     (ctl),
    .ld_data (ld_data),
    .rnd_bit (rnd_bit),
    .rnd_req (rnd_req),
    .cur_q   (cur_q),
    .below_q (below_q)
  );

  fsg_lfsr u_lfsr (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (cfg_wr),
    .seed    (cfg_pwdata[LFSR_W-1:0]),
    .step    (rnd_req),
    .rnd_bit (rnd_bit)
  );

  // spawn column beyond the grid matches no bit
  always_comb begin
    for (int i = 0; i < GRID_WIDTH; i++) begin
      spawn_mask[i] = spawn_en_r && (i == int'(spawn_col_r));
    end
  end

  // ---------------- output register ----------------
  logic                  out_valid_r;
  logic [ROW_IDX_W-1:0]  out_idx_r;
  logic [ROW_BITS_W-1:0] out_bits_r;
  logic                  out_last_r;
  logic                  can_load, out_load;
  logic [CNT_W-1:0]      pend_idx;
  logic [IDX_XW-1:0]     pend_idx_x;
  logic [BITS_XW-1:0]    rd_row_x;

  assign can_load   = !out_valid_r || out_tready;
  assign pend_idx   = emit_rd_r - 1'b1;
  assign pend_idx_x = IDX_XW'(pend_idx);
  assign rd_row_x   = BITS_XW'(rd_row);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_bits_r, out_idx_r});
  assign out_tlast  = out_last_r;
  assign in_tready  = (state_r == ST_IDLE);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    emit_rd_nxt = emit_rd_r;
    pend_nxt    = pend_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_addr     = row_r;
    rd_addr     = row_r;
    wr_data     = below_q;
    ld_data     = rd_row;
    out_load    = 1'b0;
    ctl         = '0;
    ctl.first_col = (col_r == '0);
    ctl.last_col  = (col_r == COL_LAST);

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mem_re    = 1'b1;
          rd_addr   = ROW_BOT;
          row_nxt   = ROW_SWP0;
          state_nxt = ST_RDB;
        end
      end
      ST_RDB: begin
        ctl.load_below = 1'b1;
        mem_re    = 1'b1;
        rd_addr   = row_r;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        ctl.load_cur = 1'b1;
        if (row_r == '0) begin
          ld_data = rd_row | spawn_mask;
        end
        col_nxt   = '0;
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        ctl.step = 1'b1;
        col_nxt  = col_r + 1'b1;
        if (col_r == COL_LAST) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        mem_we  = 1'b1;
        wr_addr = row_r + 1'b1;
        wr_data = below_q;
        if (row_r == '0) begin
          state_nxt = ST_WB0;
        end else begin
          // finished row becomes the row below for the next one up
          ctl.below_from_cur = 1'b1;
          mem_re    = 1'b1;
          rd_addr   = row_r - 1'b1;
          row_nxt   = row_r - 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_WB0: begin
        mem_we      = 1'b1;
        wr_addr     = '0;
        wr_data     = cur_q;
        emit_rd_nxt = '0;
        pend_nxt    = 1'b0;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        rd_addr  = emit_rd_r[ROW_W-1:0];
        out_load = pend_r && can_load;
        if (emit_rd_r != CNT_END && (!pend_r || can_load)) begin
          mem_re      = 1'b1;
          emit_rd_nxt = emit_rd_r + 1'b1;
          pend_nxt    = 1'b1;
        end else if (out_load) begin
          pend_nxt = 1'b0;
        end
        if (emit_rd_r == CNT_END && (!pend_r || can_load)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_r     <= '0;
      col_r     <= '0;
      emit_rd_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      emit_rd_r <= emit_rd_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      spawn_en_r  <= in_tdata[0];
      spawn_col_r <= in_tdata[SPAWN_COL_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= pend_idx_x[ROW_IDX_W-1:0];
      out_bits_r <= rd_row_x[ROW_BITS_W-1:0];
      out_last_r <= (pend_idx == CNT_W'(GRID_HEIGHT - 1));
    end
  end

  // ---------------- checks ----------------
  `FSG_AST_NEXT(a_item_starts_sweep, in_tvalid && in_tready, state_r == ST_RDB, "item accepted but sweep did not start")
  `FSG_AST_NOW(a_no_write_in_emit, state_r == ST_EMIT, !mem_we, "grid written during row read-back")
  `FSG_AST_NEXT(a_row_sweep_ends, state_r == ST_SWEEP && col_r == COL_LAST, state_r == ST_WB, "row sweep overran last column")

endmodule

// File: rtl/core/fsg_lfsr.sv
module fsg_lfsr
  import fsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [LFSR_W-1:0] seed,
  input  logic              step,
  output logic              rnd_bit
);

  logic [LFSR_W-1:0] lfsr_r;
  logic [LFSR_W-1:0] lfsr_nxt;

  assign rnd_bit = lfsr_r[0];

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (load) begin
      lfsr_nxt = seed;
    end else if (step) begin
      lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= SEED_RST;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule

// File: rtl/core/fsg_cell_unit.sv
module fsg_cell_unit
  import fsg_pkg::*;
#(
  parameter int GRID_WIDTH = 16
)
(
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [GRID_WIDTH-1:0] ld_data,
  input  logic                  rnd_bit,
  output logic                  rnd_req,
  output logic [GRID_WIDTH-1:0] cur_q,
  output logic [GRID_WIDTH-1:0] below_q
);

  // both rows rotate right once per step, so the cell under work is always bit 0
  logic [GRID_WIDTH-1:0] cur_r, cur_nxt;
  logic [GRID_WIDTH-1:0] below_r, below_nxt;
  logic [GRID_WIDTH-1:0] cur_m, below_m;
  logic g, bm, bl, br;
  logic mv_down, go_r, go_l;

  assign cur_q   = cur_r;
  assign below_q = below_r;

  always_comb begin
    g  = cur_r[0];
    bm = below_r[0];
    bl = ctl.first_col | below_r[GRID_WIDTH-1];
    br = ctl.last_col  | below_r[1];

    mv_down = ctl.step & g & ~bm;
    rnd_req = ctl.step & g & bm;
    go_r    = rnd_req & (rnd_bit ? ~br : (bl & ~br));
    go_l    = rnd_req & (rnd_bit ? (br & ~bl) : ~bl);

    cur_m    = cur_r;
    cur_m[0] = cur_r[0] & ~(mv_down | go_r | go_l);
    below_m  = below_r;
    if (mv_down) below_m[0] = 1'b1;
    if (go_r)    below_m[1] = 1'b1;
    if (go_l)    below_m[GRID_WIDTH-1] = 1'b1;
  end

  always_comb begin
    cur_nxt   = cur_r;
    below_nxt = below_r;
    if (ctl.load_cur) begin
      cur_nxt = ld_data;
    end else if (ctl.step) begin
      cur_nxt = {cur_m[0], cur_m[GRID_WIDTH-1:1]};
    end
    if (ctl.load_below) begin
      below_nxt = ld_data;
    end else if (ctl.below_from_cur) begin
      below_nxt = cur_r;
    end else if (ctl.step) begin
      below_nxt = {below_m[0], below_m[GRID_WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    below_r <= below_nxt;
  end

endmodule
